// ===== design/bre_pkg.sv =====
package bre_pkg;

   localparam int LEN_W = 17;
   localparam int INSIDE_W = 16;
   localparam int LOG_FRAC_W = 24;
   localparam int LOG_W = 29;
   localparam int DIV_W = 64;

   localparam logic [LEN_W-1:0] LEN_CAP = 17'd131071;
   localparam logic [19:0] PI_Q16 = 20'd205887;
   localparam logic [27:0] CHI_CAP = 28'd267386880;
   localparam logic [15:0] ENT_CAP = 16'd32768;

   localparam logic [2:0] CSR_MIN_LENGTH = 3'd0;
   localparam logic [2:0] CSR_STRONG_LIMIT = 3'd1;
   localparam logic [2:0] CSR_WEAK_LIMIT = 3'd2;
   localparam logic [2:0] CSR_PI_TOLERANCE = 3'd3;

   localparam logic [1:0] CONF_NONE = 2'd0;
   localparam logic [1:0] CONF_WEAK = 2'd1;
   localparam logic [1:0] CONF_STRONG = 2'd2;

   typedef struct packed {
      logic [12:0] min_length;
      logic [15:0] strong_entropy_limit;
      logic [15:0] weak_entropy_limit;
      logic [18:0] pi_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic sampled;
      logic last_byte;
      logic [LEN_W-1:0] count;
      logic [INSIDE_W-1:0] circle_pairs;
   } entry_type;

   typedef struct packed {
      logic [15:0] entropy_q12;
      logic [27:0] chi_square_q8;
      logic [18:0] pi_estimate_q16;
      logic looks_encrypted;
      logic [1:0] confidence_code;
   } result_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

// ===== design/bre_front.sv =====
module bre_front #(
   parameter int SAMPLE_MAX = 4096
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   input logic q_full,
   output logic q_push,
   output bre_pkg::entry_type q_entry
);

   logic [bre_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [bre_pkg::INSIDE_W-1:0] inside_ff, inside_in;
   logic sampled;
   logic [16:0] radius;
   logic [bre_pkg::LEN_W-1:0] cnt_next;
   logic [bre_pkg::INSIDE_W-1:0] inside_next;

   always_comb begin
      q_push = req_push & ~q_full;
      sampled = cnt_ff < bre_pkg::LEN_W'(SAMPLE_MAX);
      radius = 17'(16'(held_ff) * 16'(held_ff))
             + 17'(16'(req_data_byte) * 16'(req_data_byte));
      cnt_next = (cnt_ff < bre_pkg::LEN_CAP) ? cnt_ff + 1'b1 : cnt_ff;
      inside_next = inside_ff;
      if (sampled && phase_ff && radius <= 17'd65025) begin
         inside_next = inside_ff + 1'b1;
      end
      q_entry.data_byte = req_data_byte;
      q_entry.sampled = sampled;
      q_entry.last_byte = req_last_byte;
      q_entry.count = cnt_next;
      q_entry.circle_pairs = inside_next;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      held_in = held_ff;
      inside_in = inside_ff;
      if (q_push) begin
         if (req_last_byte) begin
            cnt_in = '0;
            phase_in = 1'b0;
            held_in = '0;
            inside_in = '0;
         end else begin
            cnt_in = cnt_next;
            inside_in = inside_next;
            if (sampled) begin
               phase_in = ~phase_ff;
               if (!phase_ff) begin
                  held_in = req_data_byte;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         phase_ff <= 1'b0;
         held_ff <= '0;
         inside_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         phase_ff <= phase_in;
         held_ff <= held_in;
         inside_ff <= inside_in;
      end
   end

endmodule

// ===== design/bre_fifo.sv =====
module bre_fifo (
   input logic clock,
   input logic reset,
   input logic push,
   input bre_pkg::entry_type push_entry,
   output logic full,
   input logic pop,
   output bre_pkg::entry_type pop_entry,
   output logic empty
);

   localparam int DEPTH = 4;
   localparam int AW = $clog2(DEPTH);

   bre_pkg::entry_type store [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] fill_ff, fill_in;
   logic do_push, do_pop;

   always_comb begin
      full = fill_ff == (AW+1)'(DEPTH);
      empty = fill_ff == '0;
      do_push = push & ~full;
      do_pop = pop & ~empty;
      pop_entry = store[rd_ff];
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== design/bre_div.sv =====
module bre_div (
   input logic clock,
   input logic reset,
   input bre_pkg::div_req_type req,
   output bre_pkg::div_rsp_type rsp
);

   localparam int W = bre_pkg::DIV_W;
   localparam int CNTW = $clog2(W);

   logic [W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] trial;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.num;
         den_in = req.den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rsp.done = done_ff;
      rsp.quo = quo_ff;
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== design/bre_back.sv =====
module bre_back #(
   parameter int SAMPLE_MAX = 4096
) (
   input logic clock,
   input logic reset,
   input bre_pkg::cfg_type cfg,
   input logic q_empty,
   input bre_pkg::entry_type q_entry,
   output logic q_pop,
   input logic rsp_pop,
   output logic rsp_empty,
   output bre_pkg::result_type rsp_result
);

   localparam int CW = $clog2(SAMPLE_MAX + 1);
   localparam int SW = CW + bre_pkg::LOG_W;
   localparam int QW = 2 * CW;
   localparam int W = bre_pkg::DIV_W;
   localparam int FW = bre_pkg::LOG_FRAC_W;

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_UPD = 5'd2;
   localparam logic [4:0] S_FIN = 5'd3;
   localparam logic [4:0] S_ZERO = 5'd4;
   localparam logic [4:0] S_WRD = 5'd5;
   localparam logic [4:0] S_WLAT = 5'd6;
   localparam logic [4:0] S_LOG = 5'd7;
   localparam logic [4:0] S_WACC = 5'd8;
   localparam logic [4:0] S_NLOG = 5'd9;
   localparam logic [4:0] S_NMUL = 5'd10;
   localparam logic [4:0] S_NSQ = 5'd11;
   localparam logic [4:0] S_DENT = 5'd12;
   localparam logic [4:0] S_WENT = 5'd13;
   localparam logic [4:0] S_DCHI = 5'd14;
   localparam logic [4:0] S_WCHI = 5'd15;
   localparam logic [4:0] S_DPI = 5'd16;
   localparam logic [4:0] S_WPI = 5'd17;
   localparam logic [4:0] S_VERD = 5'd18;
   localparam logic [4:0] S_OUT = 5'd19;

   function automatic logic [4:0] lead_one(input logic [bre_pkg::LEN_W-1:0] x);
      logic [4:0] k;
      k = '0;
      for (int i = 0; i < bre_pkg::LEN_W; i++) begin
         if (x[i]) begin
            k = 5'(i);
         end
      end
      return k;
   endfunction

   logic [CW-1:0] hist_mem [256];
   logic [CW-1:0] rd_ff;
   logic [7:0] raddr, waddr;
   logic [CW-1:0] wdata;
   logic we;

   logic [4:0] state_ff, state_in;
   logic [7:0] addr_ff, addr_in;
   logic last_ff, last_in;
   logic [bre_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic [bre_pkg::INSIDE_W-1:0] inside_ff, inside_in;
   logic [CW-1:0] n_ff, n_in, c_ff, c_in;
   logic [QW-1:0] c2_ff, c2_in, sum_c2_ff, sum_c2_in, nsq_ff, nsq_in;
   logic [SW-1:0] sum_cl_ff, sum_cl_in, total_ff, total_in;
   logic [31:0] ly_ff, ly_in;
   logic [FW-1:0] lfrac_ff, lfrac_in;
   logic [4:0] lk_ff, lk_in, step_ff, step_in;
   logic lsel_ff, lsel_in;
   logic [15:0] ent_ff, ent_in;
   logic [27:0] chi_ff, chi_in;
   logic [18:0] pi_ff, pi_in;
   logic [1:0] code_ff, code_in;
   logic rsp_valid_ff, rsp_valid_in;
   bre_pkg::result_type res_ff, res_in;

   bre_pkg::div_req_type div_req;
   bre_pkg::div_rsp_type div_rsp;

   logic [bre_pkg::LOG_W-1:0] lval;
   logic [63:0] sq;
   logic [32:0] y2;
   logic [4:0] kinit;
   logic [bre_pkg::LEN_W-1:0] linit_x;
   logic [bre_pkg::LEN_W-1:0] n_wide;
   logic [SW-1:0] s_val;
   logic [W-1:0] chi_a, chi_b, chi_num;
   logic [CW-1:0] pairs;
   logic [19:0] pi_dev;

   bre_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[waddr] <= wdata;
      end
      rd_ff <= hist_mem[raddr];
   end

   always_comb begin
      lval = {lk_ff, lfrac_ff};
      sq = 64'(ly_ff) * 64'(ly_ff);
      y2 = sq[63:31];
      linit_x = (state_ff == S_NLOG) ? bre_pkg::LEN_W'(n_ff) : bre_pkg::LEN_W'(rd_ff);
      kinit = lead_one(linit_x);
      n_wide = (cnt_ff < bre_pkg::LEN_W'(SAMPLE_MAX)) ? cnt_ff : bre_pkg::LEN_W'(SAMPLE_MAX);
      s_val = (total_ff > sum_cl_ff) ? total_ff - sum_cl_ff : '0;
      chi_a = W'(sum_c2_ff) << 16;
      chi_b = W'(nsq_ff) << 8;
      chi_num = ((chi_a > chi_b) ? chi_a - chi_b : '0) + W'(n_ff >> 1);
      pairs = n_ff >> 1;
      pi_dev = ({1'b0, pi_ff} > bre_pkg::PI_Q16) ? {1'b0, pi_ff} - bre_pkg::PI_Q16
                                                 : bre_pkg::PI_Q16 - {1'b0, pi_ff};

      state_in = state_ff;
      addr_in = addr_ff;
      last_in = last_ff;
      cnt_in = cnt_ff;
      inside_in = inside_ff;
      n_in = n_ff;
      c_in = c_ff;
      c2_in = c2_ff;
      sum_c2_in = sum_c2_ff;
      sum_cl_in = sum_cl_ff;
      total_in = total_ff;
      nsq_in = nsq_ff;
      ly_in = ly_ff;
      lfrac_in = lfrac_ff;
      lk_in = lk_ff;
      step_in = step_ff;
      lsel_in = lsel_ff;
      ent_in = ent_ff;
      chi_in = chi_ff;
      pi_in = pi_ff;
      code_in = code_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      q_pop = 1'b0;
      raddr = addr_ff;
      waddr = addr_ff;
      wdata = '0;
      we = 1'b0;
      div_req.start = 1'b0;
      div_req.num = '0;
      div_req.den = '0;

      unique case (state_ff)
         S_CLEAR, S_ZERO: begin
            we = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == 8'd255) begin
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_OUT;
            end
         end
         S_IDLE: begin
            raddr = q_entry.data_byte;
            if (!q_empty) begin
               q_pop = 1'b1;
               cnt_in = q_entry.count;
               inside_in = q_entry.circle_pairs;
               addr_in = q_entry.data_byte;
               last_in = q_entry.last_byte;
               if (q_entry.sampled) begin
                  state_in = S_UPD;
               end else if (q_entry.last_byte) begin
                  state_in = S_FIN;
               end
            end
         end
         S_UPD: begin
            we = 1'b1;
            wdata = rd_ff + 1'b1;
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            addr_in = '0;
            ent_in = '0;
            chi_in = '0;
            pi_in = '0;
            code_in = bre_pkg::CONF_NONE;
            sum_c2_in = '0;
            sum_cl_in = '0;
            n_in = CW'(n_wide);
            lsel_in = 1'b0;
            if (cnt_ff < bre_pkg::LEN_W'(cfg.min_length)) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            state_in = S_WLAT;
         end
         S_WLAT: begin
            we = 1'b1;
            c_in = rd_ff;
            c2_in = QW'(rd_ff) * QW'(rd_ff);
            step_in = '0;
            if (rd_ff > CW'(1)) begin
               lk_in = kinit;
               ly_in = 32'(linit_x) << (5'd31 - kinit);
               lfrac_in = '0;
               state_in = S_LOG;
            end else begin
               lk_in = '0;
               lfrac_in = '0;
               state_in = S_WACC;
            end
         end
         S_LOG: begin
            if (y2[32]) begin
               ly_in = y2[32:1];
               lfrac_in = {lfrac_ff[FW-2:0], 1'b1};
            end else begin
               ly_in = y2[31:0];
               lfrac_in = {lfrac_ff[FW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(FW - 1)) begin
               state_in = lsel_ff ? S_NMUL : S_WACC;
            end
         end
         S_WACC: begin
            sum_cl_in = sum_cl_ff + SW'(c_ff) * SW'(lval);
            sum_c2_in = sum_c2_ff + c2_ff;
            addr_in = addr_ff + 1'b1;
            state_in = (addr_ff == 8'd255) ? S_NLOG : S_WRD;
         end
         S_NLOG: begin
            lsel_in = 1'b1;
            step_in = '0;
            lk_in = kinit;
            ly_in = 32'(linit_x) << (5'd31 - kinit);
            lfrac_in = '0;
            state_in = S_LOG;
         end
         S_NMUL: begin
            total_in = SW'(n_ff) * SW'(lval);
            state_in = S_NSQ;
         end
         S_NSQ: begin
            nsq_in = QW'(n_ff) * QW'(n_ff);
            state_in = S_DENT;
         end
         S_DENT: begin
            div_req.start = 1'b1;
            div_req.num = W'(s_val) + (W'(n_ff) << 11);
            div_req.den = W'(n_ff) << 12;
            state_in = S_WENT;
         end
         S_WENT: begin
            if (div_rsp.done) begin
               ent_in = (div_rsp.quo > W'(bre_pkg::ENT_CAP)) ? bre_pkg::ENT_CAP
                                                              : div_rsp.quo[15:0];
               state_in = S_DCHI;
            end
         end
         S_DCHI: begin
            div_req.start = 1'b1;
            div_req.num = chi_num;
            div_req.den = W'(n_ff);
            state_in = S_WCHI;
         end
         S_WCHI: begin
            if (div_rsp.done) begin
               chi_in = (div_rsp.quo > W'(bre_pkg::CHI_CAP)) ? bre_pkg::CHI_CAP
                                                              : div_rsp.quo[27:0];
               state_in = S_DPI;
            end
         end
         S_DPI: begin
            if (pairs == '0) begin
               pi_in = '0;
               state_in = S_VERD;
            end else begin
               div_req.start = 1'b1;
               div_req.num = (W'(inside_ff) << 18) + W'(pairs >> 1);
               div_req.den = W'(pairs);
               state_in = S_WPI;
            end
         end
         S_WPI: begin
            if (div_rsp.done) begin
               pi_in = div_rsp.quo[18:0];
               state_in = S_VERD;
            end
         end
         S_VERD: begin
            if (ent_ff > cfg.strong_entropy_limit && pi_dev < 20'(cfg.pi_tolerance)) begin
               code_in = bre_pkg::CONF_STRONG;
            end else if (ent_ff > cfg.weak_entropy_limit) begin
               code_in = bre_pkg::CONF_WEAK;
            end else begin
               code_in = bre_pkg::CONF_NONE;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               res_in.entropy_q12 = ent_ff;
               res_in.chi_square_q8 = chi_ff;
               res_in.pi_estimate_q16 = pi_ff;
               res_in.looks_encrypted = code_ff != bre_pkg::CONF_NONE;
               res_in.confidence_code = code_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            addr_in = '0;
         end
      endcase

      rsp_empty = ~rsp_valid_ff;
      rsp_result = res_ff;
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      c2_ff <= c2_in;
      sum_c2_ff <= sum_c2_in;
      sum_cl_ff <= sum_cl_in;
      total_ff <= total_in;
      nsq_ff <= nsq_in;
      ly_ff <= ly_in;
      lfrac_ff <= lfrac_in;
      lk_ff <= lk_in;
      ent_ff <= ent_in;
      chi_ff <= chi_in;
      pi_ff <= pi_in;
      code_ff <= code_in;
      res_ff <= res_in;
      n_ff <= n_in;
      cnt_ff <= cnt_in;
      inside_ff <= inside_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         last_ff <= 1'b0;
         step_ff <= '0;
         lsel_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         last_ff <= last_in;
         step_ff <= step_in;
         lsel_ff <= lsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/byte_randomness_estimator.sv =====
// Bytes enter at one per cycle into a four-entry queue while it is not full;
// the histogram port drains each sampled byte by a read and then a write back.
// On the last byte of a buffer of at least min_length, the 256-bin walk takes
// log2 of each bin above one by 24 squaring steps, then up to three divisions.
// Reset clears control state and sweeps all 256 histogram bins to zero, during
// which bytes only fill the queue.
module byte_randomness_estimator #(
   parameter int SAMPLE_MAX = 4096
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic [15:0] rsp_entropy_q12,
   output logic [27:0] rsp_chi_square_q8,
   output logic [18:0] rsp_pi_estimate_q16,
   output logic rsp_looks_encrypted,
   output logic [1:0] rsp_confidence_code,
   input logic csr_valid,
   output logic csr_ready,
   input logic [2:0] csr_index,
   input logic [18:0] csr_data
);

   bre_pkg::cfg_type cfg_ff, cfg_in;
   bre_pkg::entry_type push_entry, pop_entry;
   bre_pkg::result_type result;
   logic q_push, q_full, q_pop, q_empty;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bre_pkg::CSR_MIN_LENGTH: cfg_in.min_length = csr_data[12:0];
            bre_pkg::CSR_STRONG_LIMIT: cfg_in.strong_entropy_limit = csr_data[15:0];
            bre_pkg::CSR_WEAK_LIMIT: cfg_in.weak_entropy_limit = csr_data[15:0];
            bre_pkg::CSR_PI_TOLERANCE: cfg_in.pi_tolerance = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length <= 13'd256;
         cfg_ff.strong_entropy_limit <= 16'd30720;
         cfg_ff.weak_entropy_limit <= 16'd28672;
         cfg_ff.pi_tolerance <= 19'd6554;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bre_front #(.SAMPLE_MAX(SAMPLE_MAX)) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .q_full(q_full),
      .q_push(q_push),
      .q_entry(push_entry)
   );

   bre_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_entry(push_entry),
      .full(q_full),
      .pop(q_pop),
      .pop_entry(pop_entry),
      .empty(q_empty)
   );

   bre_back #(.SAMPLE_MAX(SAMPLE_MAX)) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(q_empty),
      .q_entry(pop_entry),
      .q_pop(q_pop),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_result(result)
   );

   assign req_full = q_full;
   assign rsp_entropy_q12 = result.entropy_q12;
   assign rsp_chi_square_q8 = result.chi_square_q8;
   assign rsp_pi_estimate_q16 = result.pi_estimate_q16;
   assign rsp_looks_encrypted = result.looks_encrypted;
   assign rsp_confidence_code = result.confidence_code;

endmodule

// ===== tb/sv/byte_randomness_estimator_tb.sv =====
`timescale 1ns / 1ps

module byte_randomness_estimator_tb;

   localparam int SAMPLE_LIMIT = 4096;
   localparam int IDLE_LIMIT = 60000;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   class entropy_scoreboard;
      bre_pkg::cfg_type cfg;
      int unsigned hist[256];
      int unsigned byte_count;
      int unsigned inside_count;
      int unsigned held;
      bit phase;
      bre_pkg::result_type expected_q[$];
      int errors;

      function new();
         cfg.min_length = 13'd256;
         cfg.strong_entropy_limit = 16'd30720;
         cfg.weak_entropy_limit = 16'd28672;
         cfg.pi_tolerance = 19'd6554;
         errors = 0;
         clear();
      endfunction

      function void clear();
         foreach (hist[i]) hist[i] = 0;
         byte_count = 0;
         inside_count = 0;
         held = 0;
         phase = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [18:0] data);
         case (idx)
            bre_pkg::CSR_MIN_LENGTH: cfg.min_length = data[12:0];
            bre_pkg::CSR_STRONG_LIMIT: cfg.strong_entropy_limit = data[15:0];
            bre_pkg::CSR_WEAK_LIMIT: cfg.weak_entropy_limit = data[15:0];
            bre_pkg::CSR_PI_TOLERANCE: cfg.pi_tolerance = data;
            default: ;
         endcase
      endfunction

      function logic [63:0] log2_q24(logic [31:0] x);
         logic [63:0] y;
         logic [63:0] frac;
         int k;
         if (x == 0) return 64'd0;
         k = 0;
         for (int j = 31; j >= 0; j--) begin
            if (x[j]) begin
               k = j;
               break;
            end
         end
         y = 64'(x) << (31 - k);
         frac = 0;
         for (int j = 0; j < 24; j++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
               y = y >> 1;
               frac = frac | 64'd1;
            end
         end
         return (64'(k) << 24) | frac;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         bre_pkg::result_type r;
         logic [63:0] n, pairs, sum_cl, sum_c2, total, s, ent, chi, pi, pi_dev, a, bsub, num;
         if (byte_count < SAMPLE_LIMIT) begin
            hist[b]++;
            if (!phase) begin
               held = b;
               phase = 1;
            end else begin
               if (held * held + int'(b) * int'(b) <= 65025) inside_count++;
               phase = 0;
            end
         end
         if (byte_count < bre_pkg::LEN_CAP) byte_count++;
         if (!last) return;
         r = '0;
         if (byte_count >= cfg.min_length) begin
            n = (byte_count < SAMPLE_LIMIT) ? 64'(byte_count) : 64'(SAMPLE_LIMIT);
            sum_cl = 0;
            sum_c2 = 0;
            for (int i = 0; i < 256; i++) begin
               sum_cl += 64'(hist[i]) * log2_q24(hist[i]);
               sum_c2 += 64'(hist[i]) * 64'(hist[i]);
            end
            total = n * log2_q24(n[31:0]);
            s = (total > sum_cl) ? total - sum_cl : 0;
            ent = (s + n * 2048) / (n * 4096);
            if (ent > bre_pkg::ENT_CAP) ent = bre_pkg::ENT_CAP;
            a = sum_c2 << 16;
            bsub = (n * n) << 8;
            num = (a > bsub) ? a - bsub : 0;
            chi = (num + (n >> 1)) / n;
            if (chi > bre_pkg::CHI_CAP) chi = bre_pkg::CHI_CAP;
            pairs = n >> 1;
            pi = (pairs != 0) ? ((64'(inside_count) << 18) + (pairs >> 1)) / pairs : 0;
            pi_dev = (pi > bre_pkg::PI_Q16) ? pi - bre_pkg::PI_Q16 : bre_pkg::PI_Q16 - pi;
            if (ent > cfg.strong_entropy_limit && pi_dev < cfg.pi_tolerance)
               r.confidence_code = bre_pkg::CONF_STRONG;
            else if (ent > cfg.weak_entropy_limit)
               r.confidence_code = bre_pkg::CONF_WEAK;
            else
               r.confidence_code = bre_pkg::CONF_NONE;
            r.entropy_q12 = ent[15:0];
            r.chi_square_q8 = chi[27:0];
            r.pi_estimate_q16 = pi[18:0];
            r.looks_encrypted = (r.confidence_code != bre_pkg::CONF_NONE);
         end
         expected_q = {expected_q, r};
         clear();
      endfunction

      function void check_result(bre_pkg::result_type got);
         bre_pkg::result_type want;
         if (expected_q.size() == 0) begin
            fail_report("unexpected result", '0, got);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) fail_report("result mismatch", want, got);
      endfunction

      function void fail_report(string what, bre_pkg::result_type want,
                                bre_pkg::result_type got);
         errors++;
         if (errors <= 10)
            $display({"%s: exp ent=%0d chi=%0d pi=%0d enc=%0d conf=%0d",
                      "  got ent=%0d chi=%0d pi=%0d enc=%0d conf=%0d"},
               what, want.entropy_q12, want.chi_square_q8, want.pi_estimate_q16,
               want.looks_encrypted, want.confidence_code, got.entropy_q12,
               got.chi_square_q8, got.pi_estimate_q16, got.looks_encrypted,
               got.confidence_code);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [7:0] req_data_byte = 0;
   logic req_last_byte = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [15:0] rsp_entropy_q12;
   logic [27:0] rsp_chi_square_q8;
   logic [18:0] rsp_pi_estimate_q16;
   logic rsp_looks_encrypted;
   logic [1:0] rsp_confidence_code;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [18:0] csr_data = 0;

   entropy_scoreboard sb = new();
   int sender_pct = 0;
   int receiver_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int items_sent = 0;

   byte_randomness_estimator dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      bre_pkg::result_type got;
      quiet_cycles++;
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.note_byte(req_data_byte, req_last_byte);
            quiet_cycles = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            got.entropy_q12 = rsp_entropy_q12;
            got.chi_square_q8 = rsp_chi_square_q8;
            got.pi_estimate_q16 = rsp_pi_estimate_q16;
            got.looks_encrypted = rsp_looks_encrypted;
            got.confidence_code = rsp_confidence_code;
            sb.check_result(got);
            quiet_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            quiet_cycles = 0;
         end
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL byte_randomness_estimator");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= receiver_pct);
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < sender_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_full);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_buffer(int len, int mode);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: b = 8'($urandom_range(255));
            1: b = 8'($urandom_range(3));
            2: b = 8'hFF;
            default: b = 8'(i);
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic drain();
      req_push <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [18:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic random_config();
      drain();
      case ($urandom_range(3))
         0: write_csr(bre_pkg::CSR_MIN_LENGTH, 19'd1);
         1: write_csr(bre_pkg::CSR_MIN_LENGTH, 19'($urandom_range(40, 1)));
         default: write_csr(bre_pkg::CSR_MIN_LENGTH, 19'($urandom_range(8, 1)));
      endcase
      write_csr(bre_pkg::CSR_STRONG_LIMIT,
                ($urandom_range(3) == 0) ? 19'd0 : 19'($urandom_range(20000)));
      write_csr(bre_pkg::CSR_WEAK_LIMIT,
                ($urandom_range(3) == 0) ? 19'd32768 : 19'($urandom_range(16000)));
      write_csr(bre_pkg::CSR_PI_TOLERANCE,
                ($urandom_range(3) == 0) ? 19'd262144 : 19'($urandom_range(262144)));
   endtask

   task automatic random_phase(int count);
      int target;
      int len;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0) random_config();
         len = ($urandom_range(9) == 0) ? $urandom_range(100, 40) : $urandom_range(24, 1);
         send_buffer(len, $urandom_range(3));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_buffer(10, 0);
      drain();
      write_csr(bre_pkg::CSR_MIN_LENGTH, 19'd1);
      write_csr(CSR_UNUSED, 19'h7FFFF);
      send_byte(8'h00, 1);
      send_byte(8'hFF, 0);
      send_byte(8'hFF, 1);
      send_byte(8'hFF, 0);
      send_byte(8'h01, 0);
      send_byte(8'h07, 1);
      send_buffer(4, 1);
      drain();
      write_csr(bre_pkg::CSR_STRONG_LIMIT, 19'd0);
      write_csr(bre_pkg::CSR_WEAK_LIMIT, 19'd0);
      write_csr(bre_pkg::CSR_PI_TOLERANCE, 19'h7FFFF);
      send_byte(8'hA5, 1);
      send_buffer(6, 0);
      drain();
      write_csr(bre_pkg::CSR_MIN_LENGTH, 19'h7FFFF);
      send_buffer(5, 2);
      drain();
      write_csr(bre_pkg::CSR_MIN_LENGTH, 19'd256);
      write_csr(bre_pkg::CSR_STRONG_LIMIT, 19'd30720);
      write_csr(bre_pkg::CSR_WEAK_LIMIT, 19'd28672);
      write_csr(bre_pkg::CSR_PI_TOLERANCE, 19'd262144);
      send_buffer(260, 0);
      drain();

      random_config();
      random_phase(70);
      sender_pct = 60;
      random_config();
      random_phase(70);
      sender_pct = 0;
      receiver_pct = 60;
      random_config();
      hold_left = 3000;
      for (int i = 0; i < 40; i++) send_buffer($urandom_range(3, 1), 0);
      random_phase(40);
      sender_pct = 22;
      receiver_pct = 22;
      random_config();
      random_phase(70);

      req_push <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (sb.expected_q.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("PASS byte_randomness_estimator");
      end else begin
         $display("FAIL byte_randomness_estimator");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bre_pkg.sv
design/bre_front.sv
design/bre_fifo.sv
design/bre_div.sv
design/bre_back.sv
design/byte_randomness_estimator.sv
tb/sv/byte_randomness_estimator_tb.sv
